// File: rtl/smv_pkg.sv
// Shared types and constants for the sparse matrix-vector multiply unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package smv_pkg;

  // Field widths of the input and result beats.
  localparam int unsigned KIND_W = 2;
  localparam int unsigned COL_W  = 10;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned Y_W    = 48;
  localparam int unsigned SUM_W  = 64;
  localparam int unsigned FRAC_W = 16;

  // The x store is addressed by the full column field.
  localparam int unsigned XS_DEPTH = 1 << COL_W;

  // Default number of rows before the row counter wraps.
  localparam int unsigned VECTOR_DEPTH_DEF = 1024;

  // Item kinds; the remaining code is ignored.
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_NZ    = 2'd1,
    KIND_EMPTY = 2'd2
  } smv_kind_e;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] operand_value;
    logic                    row_end;
    logic signed [Y_W-1:0]   y_prior;
  } smv_in_t;

  typedef struct packed {
    logic [COL_W-1:0]      row_index;
    logic signed [Y_W-1:0] y_value;
  } smv_out_t;

  // A closed row travelling from the accumulator to the output stage.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic signed [Y_W-1:0]   y_prior;
    logic [COL_W-1:0]        row_index;
  } smv_close_t;

endpackage

// File: rtl/smv_if.sv
// Valid/ready channel interfaces for input and result beats.
// Depends on smv_pkg for the payload structs.
`timescale 1ns / 1ps

interface smv_in_if;
  import smv_pkg::*;
  logic    valid;
  logic    ready;
  smv_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface smv_out_if;
  import smv_pkg::*;
  logic     valid;
  logic     ready;
  smv_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/smv_xmem.sv
// Dense vector x store: one write and one read per cycle, registered read data.
// Depends on smv_pkg for widths and depth.
`timescale 1ns / 1ps

module smv_xmem
  import smv_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [COL_W-1:0]        waddr_i,
  input  logic signed [VAL_W-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [COL_W-1:0]        raddr_i,
  output logic signed [VAL_W-1:0] rdata_o
);

  logic signed [VAL_W-1:0] mem [XS_DEPTH];
  logic signed [VAL_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data register holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/smv_mac.sv
// Multiply-accumulate pipeline: product stage, saturating row accumulator and
// row counter. Depends on smv_pkg; x data comes from smv_xmem.
`timescale 1ns / 1ps

module smv_mac
  import smv_pkg::*;
#(
  parameter int unsigned VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Nonzero or empty-row beat entering the pipeline.
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  smv_in_t                 in_data_i,
  // x entry read for the beat held in the operand stage.
  input  logic signed [VAL_W-1:0] x_data_i,
  // Closed row toward the output stage.
  output logic                    close_valid_o,
  input  logic                    close_ready_i,
  output smv_close_t              close_data_o
);

  localparam int unsigned CNT_W = (VECTOR_DEPTH > 2) ? $clog2(VECTOR_DEPTH) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VECTOR_DEPTH - 1);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Operand stage: x data arrives from the memory alongside these fields.
  logic                    s1_valid_q, s1_valid_d;
  logic                    s1_close_q, s1_empty_q;
  logic signed [VAL_W-1:0] s1_a_q;
  logic signed [Y_W-1:0]   s1_y_q;

  // Product stage.
  logic                    s2_valid_q, s2_valid_d;
  logic                    s2_close_q;
  logic signed [SUM_W-1:0] s2_prod_q;
  logic signed [Y_W-1:0]   s2_y_q;

  logic signed [SUM_W-1:0] row_sum_q, row_sum_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;

  logic                    s2_go, s2_free, s1_free, s1_load, close_go;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;
  logic [CNT_W+COL_W-1:0]  cnt_ext;

  // Stage handshakes: a closing beat needs room downstream, others do not.
  assign s2_go      = s2_valid_q && (!s2_close_q || close_ready_i);
  assign s2_free    = !s2_valid_q || s2_go;
  assign s1_free    = !s1_valid_q || s2_free;
  assign s1_load    = in_valid_i && s1_free;
  assign close_go   = s2_go && s2_close_q;
  assign in_ready_o = s1_free;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_free) begin
      s1_valid_d = in_valid_i;
    end
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (s2_free) begin
      s2_valid_d = s1_valid_q;
    end
  end

  // Saturating add of the product onto the row sum.
  always_comb begin
    sum_wide = {row_sum_q[SUM_W-1], row_sum_q} + {s2_prod_q[SUM_W-1], s2_prod_q};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  // Accumulator and row counter next values.
  always_comb begin
    row_sum_d = row_sum_q;
    cnt_d     = cnt_q;
    if (s2_go) begin
      row_sum_d = s2_close_q ? '0 : sum_sat;
    end
    if (close_go) begin
      cnt_d = (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      row_sum_q  <= '0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      row_sum_q  <= row_sum_d;
      cnt_q      <= cnt_d;
    end
  end

  // Operand stage payload.
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_empty_q <= (in_data_i.kind == KIND_EMPTY);
      s1_close_q <= (in_data_i.kind == KIND_EMPTY) || in_data_i.row_end;
      s1_a_q     <= in_data_i.operand_value;
      s1_y_q     <= in_data_i.y_prior;
    end
  end

  // Product stage payload; an empty row contributes nothing.
  always_ff @(posedge clk_i) begin
    if (s2_free && s1_valid_q) begin
      s2_close_q <= s1_close_q;
      s2_y_q     <= s1_y_q;
      s2_prod_q  <= s1_empty_q ? '0 : SUM_W'(s1_a_q * x_data_i);
    end
  end

  assign cnt_ext       = {{COL_W{1'b0}}, cnt_q};
  assign close_valid_o = s2_valid_q && s2_close_q;
  assign close_data_o  = '{sum: sum_sat, y_prior: s2_y_q, row_index: cnt_ext[COL_W-1:0]};

  // The accumulator starts every row from zero.
  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    close_go |=> row_sum_q == '0)
    else $error("row sum not cleared after a row closed");

  // The row counter moves only when a row closes.
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !close_go |=> $stable(cnt_q))
    else $error("row counter moved without a closed row");

  // A stalled operand stage keeps its beat.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_free |=> s1_valid_q && $stable(s1_a_q) && $stable(s1_y_q))
    else $error("operand stage lost a stalled beat");

endmodule

// File: rtl/smv_rowout.sv
// Row close stage and output register: floor to Q32.16, add prior y, saturate.
// Depends on smv_pkg; fed by smv_mac.
`timescale 1ns / 1ps

module smv_rowout
  import smv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       close_valid_i,
  output logic       close_ready_o,
  input  smv_close_t close_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output smv_out_t   out_data_o
);

  localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
  localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

  logic       s3_valid_q, s3_valid_d;
  smv_close_t s3_q;
  logic       o_valid_q, o_valid_d;
  smv_out_t   o_q;

  logic                  out_free, s3_free, s3_go;
  logic signed [Y_W-1:0] floor_sum, y_sat;
  logic signed [Y_W:0]   y_wide;

  assign out_free      = !o_valid_q || out_ready_i;
  assign s3_go         = s3_valid_q && out_free;
  assign s3_free       = !s3_valid_q || out_free;
  assign close_ready_o = s3_free;

  always_comb begin
    s3_valid_d = s3_valid_q;
    if (s3_free) begin
      s3_valid_d = close_valid_i;
    end
  end

  always_comb begin
    o_valid_d = o_valid_q;
    if (out_free) begin
      o_valid_d = s3_valid_q;
    end
  end

  // Rounding down to Q32.16 is an arithmetic shift; then a saturating add.
  always_comb begin
    floor_sum = s3_q.sum[SUM_W-1:FRAC_W];
    y_wide    = {floor_sum[Y_W-1], floor_sum} + {s3_q.y_prior[Y_W-1], s3_q.y_prior};
    if (y_wide[Y_W] != y_wide[Y_W-1]) begin
      y_sat = y_wide[Y_W] ? Y_MIN : Y_MAX;
    end else begin
      y_sat = y_wide[Y_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      s3_valid_q <= s3_valid_d;
      o_valid_q  <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_free && close_valid_i) begin
      s3_q <= close_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_go) begin
      o_q <= '{row_index: s3_q.row_index, y_value: y_sat};
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_q;

  // A taken closed row always lands in the close stage.
  a_close_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    close_valid_i && close_ready_o |=> s3_valid_q)
    else $error("closed row dropped");

  // A close stage beat moves to the output register when there is room.
  a_s3_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_go |=> o_valid_q)
    else $error("close stage beat not delivered to output");

  // A blocked close stage keeps its row.
  a_s3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && !out_free |=> s3_valid_q && $stable(s3_q))
    else $error("close stage lost a stalled row");

endmodule

// File: rtl/sparse_matrix_vector_multiply_unit.sv
// Top level of the CSR sparse matrix-vector multiply unit.
// Depends on smv_pkg, smv_if, smv_xmem, smv_mac and smv_rowout.
`timescale 1ns / 1ps

// Load beats first write the Q16.16 x vector into a 1024-entry store; nonzero
// beats then stream in row-major order, and each row closes on its row-end
// nonzero or on an empty-row beat with one result beat: the floor of the
// Q32.32 row sum plus the prior y, saturated to Q32.16, with the row index.
// The unit takes one beat every cycle while input ready is high. A closed row
// moves through the operand stage (the x store read happens in the accepting
// cycle), the product stage (multiply), the close stage (accumulated sum) and
// the output register (round, add prior y, saturate). Input ready drops only
// when the output register and the close stage both hold rows that the sink
// has not taken, a closing beat waits behind them in the product stage and
// the operand stage also holds a beat. The sustained rate is set by the
// combinational saturating add of the row accumulator. Reading an x entry
// that was never loaded returns an undefined value.

module sparse_matrix_vector_multiply_unit
  import smv_pkg::*;
#(
  parameter int unsigned VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
  input logic    clk_i,
  input logic    rst_ni,
  smv_in_if.sink   in_i,
  smv_out_if.source out_o
);

  logic                    mac_ready, accept, is_row, is_load, is_nz;
  logic signed [VAL_W-1:0] x_data;
  logic                    close_valid, close_ready;
  smv_close_t              close_data;

  // Decode the accepted beat; loads and unused kinds never enter the pipeline.
  assign in_i.ready = mac_ready;
  assign accept     = in_i.valid && mac_ready;
  assign is_load    = (in_i.data.kind == KIND_LOAD);
  assign is_nz      = (in_i.data.kind == KIND_NZ);
  assign is_row     = is_nz || (in_i.data.kind == KIND_EMPTY);

  smv_xmem u_xmem (
    .clk_i   (clk_i),
    .we_i    (accept && is_load),
    .waddr_i (in_i.data.column),
    .wdata_i (in_i.data.operand_value),
    .re_i    (accept && is_nz),
    .raddr_i (in_i.data.column),
    .rdata_o (x_data)
  );

  smv_mac #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_mac (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid && is_row),
    .in_ready_o    (mac_ready),
    .in_data_i     (in_i.data),
    .x_data_i      (x_data),
    .close_valid_o (close_valid),
    .close_ready_i (close_ready),
    .close_data_o  (close_data)
  );

  smv_rowout u_rowout (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .close_valid_i (close_valid),
    .close_ready_o (close_ready),
    .close_data_i  (close_data),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_data_o    (out_o.data)
  );

endmodule

// File: test/tb_sparse_matrix_vector_multiply_unit.sv
// Self-checking testbench for the CSR sparse matrix-vector multiply unit.
// Depends on smv_pkg, smv_if and the sparse_matrix_vector_multiply_unit RTL.
`timescale 1ns / 1ps

module tb_sparse_matrix_vector_multiply_unit;
  import smv_pkg::*;

  localparam int unsigned VECTOR_DEPTH = VECTOR_DEPTH_DEF;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned RANDOM_BEATS = 550;
  localparam int unsigned FULL_RATE_BEATS = 40;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned TAIL_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic signed [Y_W-1:0] Y_POS_MAX = {1'b0, {(Y_W-1){1'b1}}};
  localparam logic signed [Y_W-1:0] Y_NEG_MAX = {1'b1, {(Y_W-1){1'b0}}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  smv_in_if  in_bus ();
  smv_out_if out_bus ();

  sparse_matrix_vector_multiply_unit #(
    .VECTOR_DEPTH(VECTOR_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Predicted state of the unit.
  logic signed [VAL_W-1:0] x_mem [XS_DEPTH];
  bit                      x_loaded [XS_DEPTH];
  int unsigned             x_cols [$];
  logic signed [SUM_W-1:0] dot_acc;
  int unsigned             row_ptr;

  // Rows that are expected on the output, oldest first.
  smv_out_t pending_rows [$];

  int unsigned fail_cnt;
  int unsigned beats_sent;
  int unsigned cycle_cnt;
  bit          src_idle_en;
  bit          snk_idle_en;
  int unsigned snk_hold;

  always #1 clk_i = ~clk_i;

  // Close the current row: floor to Q32.16, add the prior y and saturate.
  task automatic close_row(input logic signed [Y_W-1:0] y_old);
    logic signed [Y_W:0] y_sum;
    smv_out_t            row;
    y_sum = (Y_W+1)'((dot_acc >>> FRAC_W) + y_old);
    row.row_index = row_ptr[COL_W-1:0];
    if (y_sum[Y_W] != y_sum[Y_W-1]) begin
      row.y_value = y_sum[Y_W] ? Y_NEG_MAX : Y_POS_MAX;
    end else begin
      row.y_value = y_sum[Y_W-1:0];
    end
    pending_rows.push_back(row);
    dot_acc = '0;
    row_ptr = (row_ptr + 1) % VECTOR_DEPTH;
  endtask

  // Advance the predicted state by one accepted beat.
  task automatic spmv_update(input smv_in_t beat);
    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W:0]   wide;
    case (beat.kind)
      KIND_LOAD: begin
        x_mem[beat.column] = beat.operand_value;
        if (!x_loaded[beat.column]) begin
          x_loaded[beat.column] = 1'b1;
          x_cols.push_back(32'(beat.column));
        end
      end
      KIND_NZ: begin
        prod = beat.operand_value * x_mem[beat.column];
        wide = dot_acc + prod;
        // The accumulator saturates at the signed 64-bit bounds.
        if (wide[SUM_W] != wide[SUM_W-1]) begin
          dot_acc = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
          dot_acc = wide[SUM_W-1:0];
        end
        if (beat.row_end) begin
          close_row(beat.y_prior);
        end
      end
      KIND_EMPTY: begin
        close_row(beat.y_prior);
      end
      default: begin
      end
    endcase
  endtask

  function automatic smv_in_t mk_beat(input logic [KIND_W-1:0] kind, input int unsigned col,
                                      input logic [VAL_W-1:0] val, input logic last,
                                      input logic [Y_W-1:0] y_old);
    smv_in_t beat;
    beat.kind = kind;
    beat.column = col[COL_W-1:0];
    beat.operand_value = val;
    beat.row_end = last;
    beat.y_prior = y_old;
    return beat;
  endfunction

  // Values biased toward the extremes and toward magnitudes of at most 1.0.
  function automatic logic [VAL_W-1:0] pick_value();
    int near_one;
    near_one = int'($urandom_range(0, 'h20000)) - 'h10000;
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return near_one;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [Y_W-1:0] pick_y();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0: return Y_POS_MAX;
      1: return Y_NEG_MAX;
      2: return '0;
      default: return raw[Y_W-1:0];
    endcase
  endfunction

  function automatic int unsigned pick_loaded_col();
    return x_cols[$urandom_range(0, x_cols.size() - 1)];
  endfunction

  // Offer one beat, wait for the handshake and record its effect.
  task automatic send_beat(input smv_in_t beat);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= beat;
    do @(posedge clk_i); while (!in_bus.ready);
    spmv_update(beat);
    if (beat.kind != KIND_UNUSED) begin
      beats_sent++;
    end
  endtask

  // Stop offering and wait until every predicted row has come out.
  task automatic wait_rows_done();
    in_bus.valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
  endtask

  // Extremes, rounding, saturation and the odd cases of the item stream.
  task automatic test_directed();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    send_beat(mk_beat(KIND_LOAD, 0, 32'h7FFF_FFFF, 1'b0, '0));
    send_beat(mk_beat(KIND_LOAD, 1023, 32'h8000_0000, 1'b1, Y_POS_MAX));
    send_beat(mk_beat(KIND_LOAD, 1, 32'h0001_0000, 1'b0, '0));
    send_beat(mk_beat(KIND_LOAD, 2, 32'hFFFF_0000, 1'b0, '0));
    send_beat(mk_beat(KIND_LOAD, 3, 32'h0000_0001, 1'b0, '0));
    // The unused kind must leave no trace.
    send_beat(mk_beat(KIND_UNUSED, 5, $urandom(), 1'b1, pick_y()));
    send_beat(mk_beat(KIND_NZ, 1, 32'h0003_0000, 1'b1, 48'h0000_0001_0000));
    send_beat(mk_beat(KIND_EMPTY, 0, '0, 1'b0, Y_POS_MAX));
    send_beat(mk_beat(KIND_EMPTY, 1023, '1, 1'b1, Y_NEG_MAX));
    // Sub-LSB products round toward minus infinity.
    send_beat(mk_beat(KIND_NZ, 3, 32'hFFFF_FFFF, 1'b1, '0));
    send_beat(mk_beat(KIND_NZ, 3, 32'h0000_0001, 1'b1, '0));
    // Positive accumulator and output saturation.
    repeat (3) send_beat(mk_beat(KIND_NZ, 0, 32'h7FFF_FFFF, 1'b0, '0));
    send_beat(mk_beat(KIND_NZ, 0, 32'h7FFF_FFFF, 1'b1, Y_POS_MAX));
    // Negative accumulator and output saturation.
    repeat (2) send_beat(mk_beat(KIND_NZ, 1023, 32'h7FFF_FFFF, 1'b0, '0));
    send_beat(mk_beat(KIND_NZ, 1023, 32'h7FFF_FFFF, 1'b1, Y_NEG_MAX));
    send_beat(mk_beat(KIND_NZ, 1023, 32'h8000_0000, 1'b1, '0));
    // A load in the middle of a row keeps the partial sum.
    send_beat(mk_beat(KIND_NZ, 2, 32'h0002_0000, 1'b0, '0));
    send_beat(mk_beat(KIND_LOAD, 4, 32'h0005_0000, 1'b0, '0));
    send_beat(mk_beat(KIND_NZ, 4, 32'h0001_0000, 1'b1, '0));
    // An empty row closes a row that still holds a partial sum.
    send_beat(mk_beat(KIND_NZ, 1, 32'h1234_5678, 1'b0, '0));
    send_beat(mk_beat(KIND_EMPTY, 7, '0, 1'b0, 48'h7));
    send_beat(mk_beat(KIND_EMPTY, 0, '0, 1'b0, '0));
    wait_rows_done();
  endtask

  // Hold the sink off long enough that the unit fills and stalls its input.
  task automatic test_output_stall();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    snk_hold = HOLD_CYCLES;
    repeat (40) begin
      if ($urandom_range(0, 1) == 0) begin
        send_beat(mk_beat(KIND_EMPTY, $urandom_range(0, 1023), $urandom(), 1'b0, pick_y()));
      end else begin
        send_beat(mk_beat(KIND_NZ, pick_loaded_col(), pick_value(), 1'b1, pick_y()));
      end
    end
    wait_rows_done();
  endtask

  // Mostly well-formed rows with random content, mixed with noise and broken rows.
  task automatic test_random_rows();
    int unsigned target;
    int unsigned choice;
    int unsigned nz_cnt;
    int unsigned seg;
    target = beats_sent + RANDOM_BEATS;
    seg = 0;
    while (beats_sent < target) begin
      if (seg == 0) begin
        seg = $urandom_range(10, 30);
        src_idle_en = $urandom_range(0, 3) != 0;
        snk_idle_en = $urandom_range(0, 3) != 0;
      end
      seg--;
      choice = $urandom_range(0, 19);
      if (choice < 3) begin
        repeat ($urandom_range(1, 4)) begin
          send_beat(mk_beat(KIND_LOAD, $urandom_range(0, 1023), pick_value(),
                            1'($urandom_range(0, 1)), pick_y()));
        end
      end else if (choice == 3) begin
        send_beat(mk_beat(KIND_UNUSED, $urandom_range(0, 1023), $urandom(),
                          1'($urandom_range(0, 1)), pick_y()));
      end else if (choice == 4) begin
        // Broken row: pending nonzeros, maybe a load, closed by either kind.
        repeat ($urandom_range(1, 3)) begin
          send_beat(mk_beat(KIND_NZ, pick_loaded_col(), pick_value(), 1'b0, pick_y()));
        end
        if ($urandom_range(0, 1) == 0) begin
          send_beat(mk_beat(KIND_LOAD, $urandom_range(0, 1023), pick_value(), 1'b0, pick_y()));
        end
        if ($urandom_range(0, 1) == 0) begin
          send_beat(mk_beat(KIND_EMPTY, $urandom_range(0, 1023), $urandom(),
                            1'($urandom_range(0, 1)), pick_y()));
        end else begin
          send_beat(mk_beat(KIND_NZ, pick_loaded_col(), pick_value(), 1'b1, pick_y()));
        end
      end else begin
        nz_cnt = $urandom_range(0, 6);
        if (nz_cnt == 0) begin
          send_beat(mk_beat(KIND_EMPTY, $urandom_range(0, 1023), $urandom(),
                            1'($urandom_range(0, 1)), pick_y()));
        end else begin
          for (int unsigned k = 1; k <= nz_cnt; k++) begin
            send_beat(mk_beat(KIND_NZ, pick_loaded_col(), pick_value(), k == nz_cnt,
                              pick_y()));
          end
        end
      end
    end
    wait_rows_done();
  endtask

  // Rows back to back with both sides always ready to end the run.
  task automatic test_full_rate();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    repeat (FULL_RATE_BEATS) begin
      if ($urandom_range(0, 3) == 0) begin
        send_beat(mk_beat(KIND_NZ, pick_loaded_col(), pick_value(), 1'b1, pick_y()));
      end else begin
        send_beat(mk_beat(KIND_EMPTY, $urandom_range(0, 1023), $urandom(), 1'b0, pick_y()));
      end
    end
    wait_rows_done();
  endtask

  // Stimulus sequence.
  initial begin
    in_bus.valid <= 1'b0;
    in_bus.data  <= '0;
    dot_acc = '0;
    row_ptr = 0;
    fail_cnt = 0;
    beats_sent = 0;
    snk_hold = 0;
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_output_stall();
    test_random_rows();
    test_full_rate();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending_rows.size() == 0) begin
      $display("PASS sparse_matrix_vector_multiply_unit");
    end else begin
      $display("FAIL sparse_matrix_vector_multiply_unit");
    end
    $finish;
  end

  // Sink ready: long hold-offs on request, otherwise random bursts of idling.
  initial begin : sink_ready
    int unsigned gap;
    gap = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (snk_hold != 0) begin
        snk_hold--;
        out_bus.ready <= 1'b0;
      end else if (gap != 0) begin
        gap--;
        out_bus.ready <= 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(0, 4);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result beat with the oldest predicted row.
  always @(posedge clk_i) begin : check_rows
    smv_out_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_rows.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected row: expected none, got row_index %0d y_value %0d",
                 $time, out_bus.data.row_index, out_bus.data.y_value);
      end else begin
        want = pending_rows.pop_front();
        if (out_bus.data.row_index !== want.row_index) begin
          fail_cnt++;
          $display("%0t: row_index mismatch: expected %0d, got %0d",
                   $time, want.row_index, out_bus.data.row_index);
        end
        if (out_bus.data.y_value !== want.y_value) begin
          fail_cnt++;
          $display("%0t: y_value mismatch on row %0d: expected %0d, got %0d",
                   $time, want.row_index, want.y_value, out_bus.data.y_value);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL sparse_matrix_vector_multiply_unit");
      $finish;
    end
  end

endmodule

// File: filelist.f
rtl/smv_pkg.sv
rtl/smv_if.sv
rtl/smv_xmem.sv
rtl/smv_mac.sv
rtl/smv_rowout.sv
rtl/sparse_matrix_vector_multiply_unit.sv
test/tb_sparse_matrix_vector_multiply_unit.sv
